// File: rtl/i2c_master_transfer_sequencer_macros.svh
// Assertion macros used by the I2C transfer sequencer checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CMTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cmts check failed");

// Next-cycle implication, checked out of reset.
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cmts check failed");

`endif

// File: rtl/i2cmts_pkg.sv
// Types and constants of the I2C master transfer sequencer.
// Used by the step logic, the top level and the checker.
package i2cmts_pkg;

  // Longest transfer, in bytes
  localparam logic [7:0] MAX_LEN = 8'd255;

  typedef enum logic [1:0] {
    REQ_START_WR = 2'd0,
    REQ_START_RD = 2'd1,
    REQ_EVENT    = 2'd2,
    REQ_ERROR    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_OK   = 2'd2,
    ST_ERR  = 2'd3
  } status_e;

  // Bus event flag positions
  localparam int unsigned EV_SB   = 0;
  localparam int unsigned EV_ADDR = 1;
  localparam int unsigned EV_BTF  = 2;
  localparam int unsigned EV_RXNE = 3;
  localparam int unsigned EV_TXE  = 4;

  // Bus error flag positions
  localparam int unsigned ER_BERR = 0;
  localparam int unsigned ER_ARLO = 1;
  localparam int unsigned ER_AF   = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] xfer_length;
    logic [4:0] event_flags;
    logic [2:0] error_flags;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } req_t;

  typedef struct packed {
    logic              read_dir;
    logic [7:0]        addr_byte;
    logic [7:0]        total_len;
    logic signed [9:0] remaining;
    logic [7:0]        pointer;
    logic              busy;
  } state_t;

  typedef struct packed {
    logic       send_start;
    logic       send_stop;
    logic       dreg_write;
    logic [7:0] dreg_value;
    logic       rx_valid;
    logic [7:0] rx_value;
    logic [7:0] buf_pointer;
    logic [1:0] xfer_status;
    logic [7:0] byte_count;
  } result_t;

endpackage

// File: rtl/i2cmts_step.sv
// Decision logic for one word: next transfer state and bus actions.
// Depends on i2cmts_pkg.
module i2cmts_step import i2cmts_pkg::*; (
  input  req_t    req_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t res_o
);

  logic [7:0]        len;
  logic signed [9:0] rem_dec;
  logic              done_ok;
  logic              done_err;
  logic              ev_sb, ev_addr, ev_btf, ev_rxne, ev_txe;

  assign len     = (req_i.xfer_length > MAX_LEN) ? MAX_LEN : req_i.xfer_length;
  assign rem_dec = state_i.remaining - 10'sd1;
  assign ev_sb   = req_i.event_flags[EV_SB];
  assign ev_addr = req_i.event_flags[EV_ADDR];
  assign ev_btf  = req_i.event_flags[EV_BTF];
  assign ev_rxne = req_i.event_flags[EV_RXNE];
  assign ev_txe  = req_i.event_flags[EV_TXE];

  // Decide the bus actions and update the transfer state
  always_comb begin
    state_o  = state_i;
    res_o    = '0;
    done_ok  = 1'b0;
    done_err = 1'b0;
    res_o.xfer_status = ST_BUSY;

    case (req_e'(req_i.req_type))
      REQ_START_WR, REQ_START_RD: begin
        if (req_i.req_type == REQ_START_RD && len == 8'd0) begin
          // empty read finishes at once
          res_o.xfer_status = ST_OK;
        end else begin
          state_o.read_dir  = req_i.req_type[0];
          state_o.addr_byte = {req_i.dev_addr, req_i.req_type[0]};
          state_o.total_len = len;
          state_o.remaining = signed'({2'b00, len});
          state_o.pointer   = 8'd0;
          state_o.busy      = 1'b1;
          res_o.send_start  = 1'b1;
        end
      end
      REQ_EVENT: begin
        if (!state_i.busy) begin
          res_o.xfer_status = ST_IDLE;
        end else begin
          if (ev_sb) begin
            res_o.dreg_write = 1'b1;
            res_o.dreg_value = state_i.addr_byte;
          end
          // single-byte read: stop right at address acknowledge
          if (ev_addr && state_i.read_dir && state_i.total_len == 8'd1) begin
            res_o.send_stop = 1'b1;
          end
          if (!ev_sb) begin
            if (state_i.read_dir && (ev_btf || ev_rxne)) begin
              res_o.rx_valid    = 1'b1;
              res_o.rx_value    = req_i.rx_byte;
              state_o.pointer   = state_i.pointer + 8'd1;
              state_o.remaining = rem_dec;
              if (rem_dec <= 10'sd0) begin
                done_ok = 1'b1;
              end else if (rem_dec == 10'sd1) begin
                res_o.send_stop = 1'b1;
              end
            end else if (!state_i.read_dir && (ev_btf || ev_txe)) begin
              res_o.dreg_write  = 1'b1;
              state_o.remaining = rem_dec;
              if (state_i.remaining > 10'sd0) begin
                res_o.dreg_value = req_i.tx_byte;
                state_o.pointer  = state_i.pointer + 8'd1;
              end else if (state_i.remaining == 10'sd0) begin
                // all sent: stop, together with a dummy write
                res_o.send_stop = 1'b1;
              end else begin
                done_ok = 1'b1;
              end
            end
          end
        end
      end
      REQ_ERROR: begin
        if (!state_i.busy) begin
          res_o.xfer_status = ST_IDLE;
        end else begin
          done_err        = |req_i.error_flags;
          res_o.send_stop = req_i.error_flags[ER_AF];
        end
      end
      default: begin
        res_o.xfer_status = ST_IDLE;
      end
    endcase

    // Close the transfer
    if (done_err) begin
      state_o.busy      = 1'b0;
      res_o.xfer_status = ST_ERR;
    end else if (done_ok) begin
      state_o.busy      = 1'b0;
      res_o.xfer_status = ST_OK;
      res_o.byte_count  = state_i.total_len;
    end

    res_o.buf_pointer = state_o.pointer;
  end

endmodule

// File: rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer
//
// Input channel (in_valid_i / in_stall_o) takes one word per request: a start
// of a write or read transfer, a set of bus event flags, or a set of bus error
// flags. Output channel (out_valid_o / out_stall_i) returns exactly one word
// per input word: START/STOP requests, a data register write, a received byte
// for the buffer, the buffer pointer, transfer status and byte count.
//
// An accepted word sits in the input register until the result register is
// free, then is decided and moves into the result register, which drives
// out_valid_o. The decision is one pass of short logic on the held transfer
// state, so one word is accepted per cycle while the output is drained.
//
// When the receiver stalls, the result register holds its word and the input
// register holds the next one; in_stall_o rises only once both are full.
// Reset empties both registers and clears the transfer state to idle.
// Depends on i2cmts_pkg and i2cmts_step.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] xfer_length_i,
  input  logic [4:0] event_flags_i,
  input  logic [2:0] error_flags_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       send_start_o,
  output logic       send_stop_o,
  output logic       dreg_write_o,
  output logic [7:0] dreg_value_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_value_o,
  output logic [7:0] buf_pointer_o,
  output logic [1:0] xfer_status_o,
  output logic [7:0] byte_count_o
);

  req_t    in_q;
  logic    in_valid_q, in_valid_d;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, advance, in_take;

  // Handshake and flow
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  i2cmts_step u_step (
    .req_i   (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Hold control and transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{req_type:    req_type_i,
                dev_addr:    dev_addr_i,
                xfer_length: xfer_length_i,
                event_flags: event_flags_i,
                error_flags: error_flags_i,
                rx_byte:     rx_byte_i,
                tx_byte:     tx_byte_i};
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign send_start_o  = res_q.send_start;
  assign send_stop_o   = res_q.send_stop;
  assign dreg_write_o  = res_q.dreg_write;
  assign dreg_value_o  = res_q.dreg_value;
  assign rx_valid_o    = res_q.rx_valid;
  assign rx_value_o    = res_q.rx_value;
  assign buf_pointer_o = res_q.buf_pointer;
  assign xfer_status_o = res_q.xfer_status;
  assign byte_count_o  = res_q.byte_count;

endmodule

// File: rtl/i2cmts_checker.sv
// Port-level checks of the I2C master transfer sequencer, bound to the top.
// Depends on i2cmts_pkg and the assertion macro header.
`include "i2c_master_transfer_sequencer_macros.svh"

module i2cmts_checker import i2cmts_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       send_start_o,
  input logic       send_stop_o,
  input logic       dreg_write_o,
  input logic       rx_valid_o,
  input logic [7:0] buf_pointer_o,
  input logic [1:0] xfer_status_o,
  input logic [7:0] byte_count_o
);

  // A stalled result word stays and keeps its status
  `I2CMTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(xfer_status_o) && $stable(buf_pointer_o))

  // A start word only opens a transfer: no other bus action with it
  `I2CMTS_ASSERT_NOW(a_start_alone, out_valid_o && send_start_o,
    xfer_status_o == ST_BUSY && !dreg_write_o && !rx_valid_o && !send_stop_o
    && buf_pointer_o == 8'd0)

  // A byte count is reported only on a good completion
  `I2CMTS_ASSERT_NOW(a_count_ok, out_valid_o && byte_count_o != 8'd0,
    xfer_status_o == ST_OK)

  // Idle or failed words never move data
  `I2CMTS_ASSERT_NOW(a_no_data, out_valid_o &&
    (xfer_status_o == ST_IDLE || xfer_status_o == ST_ERR),
    !dreg_write_o && !rx_valid_o && !send_start_o)

  // The input stalls only behind a stalled result word
  `I2CMTS_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (.*);
